FILE: sv/spdc_pkg.sv
// ----------------------------------------------------------------------------
// spdc_pkg
// Shared constants, event codes and types for the two-axis servo command
// parser.
// ----------------------------------------------------------------------------
package spdc_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned DutyW   = 7;
  localparam int unsigned CountW  = 3;
  localparam int unsigned DigitsN = 3;

  localparam logic [CharW-1:0]  CharCr    = 8'd13;
  localparam logic [CharW-1:0]  CharZero  = 8'h30;
  localparam logic [DutyW-1:0]  DutyMin   = 7'd63;
  localparam logic [DutyW-1:0]  DutyMax   = 7'd125;
  localparam logic [DutyW-1:0]  DutyReset = 7'd94;
  localparam logic [CountW-1:0] CountSat  = 3'd4;
  localparam logic [CountW-1:0] CountKeep = 3'd3;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_REJECT  = 2'd1,
    EV_X_TAKEN = 2'd2,
    EV_APPLIED = 2'd3
  } event_t;

  typedef logic [DigitsN-1:0][CharW-1:0] digits_t;

  // Verdict on one finished line.
  typedef struct packed {
    logic             ok;
    logic [DutyW-1:0] value;
  } chk_res_t;

endpackage

FILE: sv/spdc_if.sv
// ----------------------------------------------------------------------------
// spdc_if
// Valid/ready channels: received bytes in, one result per byte out.
// ----------------------------------------------------------------------------
interface spdc_in_if;
  logic                        valid;
  logic                        ready;
  logic [spdc_pkg::CharW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spdc_out_if;
  logic                        valid;
  logic                        ready;
  logic [spdc_pkg::CharW-1:0]  echo_byte;
  logic [1:0]                  event_res;
  logic                        axis_next;
  logic [spdc_pkg::DutyW-1:0]  duty_x;
  logic [spdc_pkg::DutyW-1:0]  duty_y;

  modport source (output valid, output echo_byte, output event_res, output axis_next,
                  output duty_x, output duty_y, input ready);
  modport sink   (input valid, input echo_byte, input event_res, input axis_next,
                  input duty_x, input duty_y, output ready);
endinterface

FILE: sv/spdc_line_check.sv
// ----------------------------------------------------------------------------
// spdc_line_check
// Checks the kept characters of a finished line and forms its decimal value.
// ----------------------------------------------------------------------------
module spdc_line_check (
  input  logic [spdc_pkg::CountW-1:0] char_count,
  input  spdc_pkg::digits_t           digits,
  output spdc_pkg::chk_res_t          res
);

  logic       ok2, ok3;
  logic [6:0] val2;
  logic [7:0] val3;
  logic [7:0] val;
  logic       fmt_ok;
  logic [3:0] n0, n1, n2;

  function automatic logic in_rng(input logic [7:0] c, input logic [3:0] lo,
                                  input logic [3:0] hi);
    in_rng = (c >= (spdc_pkg::CharZero + {4'd0, lo})) &&
             (c <= (spdc_pkg::CharZero + {4'd0, hi}));
  endfunction

  always_comb begin
    n0 = digits[0][3:0];
    n1 = digits[1][3:0];
    n2 = digits[2][3:0];

    ok2 = in_rng(digits[0], 4'd6, 4'd9) && in_rng(digits[1], 4'd0, 4'd9);
    ok3 = in_rng(digits[0], 4'd0, 4'd1) && in_rng(digits[1], 4'd0, 4'd2) &&
          in_rng(digits[2], 4'd0, 4'd9);

    val2 = 7'({3'd0, n0} * 7'd10) + {3'd0, n1};
    val3 = 8'({4'd0, n0} * 8'd100) + 8'({4'd0, n1} * 8'd10) + {4'd0, n2};

    fmt_ok = 1'b0;
    val    = '0;
    case (char_count)
      3'd2: begin
        fmt_ok = ok2;
        val    = {1'b0, val2};
      end
      3'd3: begin
        fmt_ok = ok3;
        val    = val3;
      end
      default: begin
        fmt_ok = 1'b0;
        val    = '0;
      end
    endcase

    res.ok    = fmt_ok && (val >= {1'b0, spdc_pkg::DutyMin}) &&
                (val <= {1'b0, spdc_pkg::DutyMax});
    res.value = val[6:0];
  end

endmodule

FILE: sv/servo_pair_decimal_command_parser_core.sv
// ----------------------------------------------------------------------------
// servo_pair_decimal_command_parser_core
// Two-axis servo command parser: echoes every byte, collects decimal lines,
// takes x then y, and applies both duty values together.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                        | transfer when
//  --------+-----+------------------------------------------------+-------------------
//  in_ch   | in  | rx_byte[7:0]                                   | valid && ready
//  out_ch  | out | echo_byte, event_res, axis_next, duty_x/duty_y | valid && ready
//
//  One result per byte, one byte per cycle sustained while the output is not
//  stalled. Each byte passes the input register, then the parse step feeding
//  the output register. The parse step is the only place line state changes,
//  so bytes are handled strictly in order, one at a time.
//  Reset (rst_n low, synchronous) empties both registers, clears the line
//  count, selects axis x and sets both duty values to 94.
//  A stalled output holds its result; the input register keeps accepting as
//  long as its byte can move on in the same cycle.
//
module servo_pair_decimal_command_parser_core (
  input  logic              clk,
  input  logic              rst_n,
  spdc_in_if.sink           in_ch,
  spdc_out_if.source        out_ch
);

  // Input register
  logic                        in_vld_r;
  logic [spdc_pkg::CharW-1:0]  in_byte_r;

  // Line and axis state
  logic [spdc_pkg::CountW-1:0] count_r, count_nxt;
  spdc_pkg::digits_t           digits_r;
  logic                        axis_r, axis_nxt;
  logic [spdc_pkg::DutyW-1:0]  pend_x_r;
  logic [spdc_pkg::DutyW-1:0]  duty_x_r, duty_x_nxt;
  logic [spdc_pkg::DutyW-1:0]  duty_y_r, duty_y_nxt;

  // Output register
  logic                        out_vld_r;
  logic [spdc_pkg::CharW-1:0]  out_byte_r;
  spdc_pkg::event_t            out_ev_r, ev_nxt;
  logic                        out_axis_r;
  logic [spdc_pkg::DutyW-1:0]  out_dx_r, out_dy_r;

  logic                        advance;
  logic                        is_cr;
  logic                        store_en;
  logic                        take_x;
  spdc_pkg::chk_res_t          chk;

  // Move the held byte through the parse step when the output slot is free
  // or is being emptied this cycle.
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  spdc_line_check u_check (
    .char_count (count_r),
    .digits     (digits_r),
    .res        (chk)
  );

  always_comb begin
    is_cr      = (in_byte_r == spdc_pkg::CharCr);
    count_nxt  = count_r;
    axis_nxt   = axis_r;
    duty_x_nxt = duty_x_r;
    duty_y_nxt = duty_y_r;
    ev_nxt     = spdc_pkg::EV_NONE;
    store_en   = 1'b0;
    take_x     = 1'b0;

    if (is_cr) begin
      // Empty line: echo only.
      if (count_r != '0) begin
        count_nxt = '0;
        if (!chk.ok) begin
          ev_nxt = spdc_pkg::EV_REJECT;
        end else if (!axis_r) begin
          take_x   = 1'b1;
          axis_nxt = 1'b1;
          ev_nxt   = spdc_pkg::EV_X_TAKEN;
        end else begin
          duty_x_nxt = pend_x_r;
          duty_y_nxt = chk.value;
          axis_nxt   = 1'b0;
          ev_nxt     = spdc_pkg::EV_APPLIED;
        end
      end
    end else begin
      // Keep the first three characters; saturate the count past them.
      store_en = (count_r < spdc_pkg::CountKeep);
      if (count_r < spdc_pkg::CountSat) begin
        count_nxt = count_r + 3'd1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      count_r   <= '0;
      axis_r    <= 1'b0;
      duty_x_r  <= spdc_pkg::DutyReset;
      duty_y_r  <= spdc_pkg::DutyReset;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        count_r   <= count_nxt;
        axis_r    <= axis_nxt;
        duty_x_r  <= duty_x_nxt;
        duty_y_r  <= duty_y_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (advance) begin
      if (store_en) begin
        digits_r[count_r[1:0]] <= in_byte_r;
      end
      if (take_x) begin
        pend_x_r <= chk.value;
      end
      out_byte_r <= in_byte_r;
      out_ev_r   <= ev_nxt;
      out_axis_r <= axis_nxt;
      out_dx_r   <= duty_x_nxt;
      out_dy_r   <= duty_y_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.echo_byte = out_byte_r;
  assign out_ch.event_res = out_ev_r;
  assign out_ch.axis_next = out_axis_r;
  assign out_ch.duty_x    = out_dx_r;
  assign out_ch.duty_y    = out_dy_r;

endmodule

FILE: sv/spdc_checker.sv
// ----------------------------------------------------------------------------
// spdc_checker
// Port-level checks on the servo command parser, bound to the top level.
// ----------------------------------------------------------------------------
module spdc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [spdc_pkg::CharW-1:0]  echo_byte,
  input logic [1:0]                  event_res,
  input logic                        axis_next,
  input logic [spdc_pkg::DutyW-1:0]  duty_x,
  input logic [spdc_pkg::DutyW-1:0]  duty_y
);

  // Output register empties on reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(echo_byte) && $stable(event_res)
      && $stable(axis_next) && $stable(duty_x) && $stable(duty_y))
    else $error("stalled result changed");

  // Only a line end raises an event.
  a_event_on_cr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res != spdc_pkg::EV_NONE |-> echo_byte == spdc_pkg::CharCr)
    else $error("event on a byte other than carriage return");

  // Axis moves to y after x is taken and back to x after a pair is applied.
  a_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == spdc_pkg::EV_X_TAKEN || event_res == spdc_pkg::EV_APPLIED)
      |-> axis_next == (event_res == spdc_pkg::EV_X_TAKEN))
    else $error("axis select inconsistent with event");

  // Applied duties stay in the legal range.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> duty_x >= spdc_pkg::DutyMin && duty_x <= spdc_pkg::DutyMax
      && duty_y >= spdc_pkg::DutyMin && duty_y <= spdc_pkg::DutyMax)
    else $error("duty value out of range");

endmodule

bind servo_pair_decimal_command_parser_core spdc_checker u_spdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .echo_byte (out_ch.echo_byte),
  .event_res (out_ch.event_res),
  .axis_next (out_ch.axis_next),
  .duty_x    (out_ch.duty_x),
  .duty_y    (out_ch.duty_y)
);

FILE: sim/servo_pair_decimal_command_parser_core_tb.sv
// ----------------------------------------------------------------------------
// servo_pair_decimal_command_parser_core_tb
// Self-checking bench for the two-axis servo command parser. Feeds directed
// and random command lines, including good values, out-of-range values,
// short, long and empty lines and non-digit bytes. A local line model
// predicts echo, event, axis and both duty values for every byte. Both
// channels idle at random; one phase stalls the output for a long stretch
// and one drains after every line.
// ----------------------------------------------------------------------------
module servo_pair_decimal_command_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 80;

  // One expected result, in the order of the output channel fields.
  typedef struct packed {
    logic [spdc_pkg::CharW-1:0] echo_byte;
    spdc_pkg::event_t           event_res;
    logic                       axis_next;
    logic [spdc_pkg::DutyW-1:0] duty_x;
    logic [spdc_pkg::DutyW-1:0] duty_y;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n;

  spdc_in_if  in_ch ();
  spdc_out_if out_ch ();

  servo_pair_decimal_command_parser_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Line model state, at its reset values.
  logic [spdc_pkg::CountW-1:0] line_len   = '0;
  spdc_pkg::digits_t           line_chars = '0;
  logic                        axis_y     = 1'b0;
  logic [spdc_pkg::DutyW-1:0]  held_x     = '0;
  logic [spdc_pkg::DutyW-1:0]  applied_dx = spdc_pkg::DutyReset;
  logic [spdc_pkg::DutyW-1:0]  applied_dy = spdc_pkg::DutyReset;

  parse_result_t result_q[$];
  parse_result_t want_res;

  int  error_count   = 0;
  int  sent_count    = 0;
  int  cycle_count   = 0;
  int  x_taken_count = 0;
  int  applied_count = 0;
  int  reject_count  = 0;
  int  empty_count   = 0;
  bit  send_idle     = 1'b1;
  bit  recv_idle     = 1'b1;
  int  hold_request  = 0;

  // True when c is an ASCII digit whose value lies in lo..hi.
  function automatic bit digit_in(input logic [spdc_pkg::CharW-1:0] c, input int lo,
                                  input int hi);
    return (int'(c) >= int'(spdc_pkg::CharZero) + lo) &&
           (int'(c) <= int'(spdc_pkg::CharZero) + hi);
  endfunction

  function automatic int digit_val(input logic [spdc_pkg::CharW-1:0] c);
    return int'(c) - int'(spdc_pkg::CharZero);
  endfunction

  // Advance the line model by one byte and return the result it causes.
  function automatic parse_result_t parse_byte(input logic [spdc_pkg::CharW-1:0] c);
    parse_result_t    r;
    spdc_pkg::event_t ev;
    bit               ok;
    int               v;
    ev = spdc_pkg::EV_NONE;
    ok = 1'b0;
    v  = 0;
    if (c == spdc_pkg::CharCr) begin
      if (line_len != '0) begin
        // Accept only the two-digit or the three-digit shape, then the range.
        if (line_len == 3'd2) begin
          ok = digit_in(line_chars[0], 6, 9) && digit_in(line_chars[1], 0, 9);
          v  = digit_val(line_chars[0]) * 10 + digit_val(line_chars[1]);
        end else if (line_len == 3'd3) begin
          ok = digit_in(line_chars[0], 0, 1) && digit_in(line_chars[1], 0, 2) &&
               digit_in(line_chars[2], 0, 9);
          v  = digit_val(line_chars[0]) * 100 + digit_val(line_chars[1]) * 10 +
               digit_val(line_chars[2]);
        end
        ok = ok && (v >= int'(spdc_pkg::DutyMin)) && (v <= int'(spdc_pkg::DutyMax));
        if (!ok) begin
          ev = spdc_pkg::EV_REJECT;
          reject_count++;
        end else if (!axis_y) begin
          held_x = spdc_pkg::DutyW'(v);
          axis_y = 1'b1;
          ev     = spdc_pkg::EV_X_TAKEN;
          x_taken_count++;
        end else begin
          applied_dx = held_x;
          applied_dy = spdc_pkg::DutyW'(v);
          axis_y     = 1'b0;
          ev         = spdc_pkg::EV_APPLIED;
          applied_count++;
        end
        line_len = '0;
      end else begin
        empty_count++;
      end
    end else begin
      // Keep the first three characters; saturate the count.
      if (line_len < spdc_pkg::CountKeep) line_chars[line_len] = c;
      if (line_len < spdc_pkg::CountSat) line_len = line_len + 1'b1;
    end
    r.echo_byte = c;
    r.event_res = ev;
    r.axis_next = axis_y;
    r.duty_x    = applied_dx;
    r.duty_y    = applied_dy;
    return r;
  endfunction

  // Offer one byte after a random gap and hold it until the transfer.
  // Valid stays high on return so a back-to-back byte needs no toggle.
  task automatic send_byte(input logic [spdc_pkg::CharW-1:0] b);
    int gap;
    gap = send_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.rx_byte <= b;
    in_ch.valid   <= 1'b1;
    result_q.push_back(parse_byte(b));
    sent_count++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait on the clock so a later raise lands in a fresh time step.
  task automatic release_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    release_input();
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // Send the characters of s, then a carriage return.
  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(spdc_pkg::CharCr);
  endtask

  function automatic logic [spdc_pkg::CharW-1:0] noise_char();
    logic [spdc_pkg::CharW-1:0] edge_chars [7];
    edge_chars = '{"/", ":", "5", "6", "1", "2", "3"};
    case ($urandom_range(0, 3))
      0:       return spdc_pkg::CharZero + spdc_pkg::CharW'($urandom_range(0, 9));
      1:       return edge_chars[$urandom_range(0, 6)];
      default: return spdc_pkg::CharW'($urandom_range(0, 255));
    endcase
  endfunction

  // Build one random line: mostly well-formed values, then well-shaped
  // lines of random digits in or out of range, empty lines, noise and corrupted good lines.
  task automatic send_random_line();
    logic [spdc_pkg::CharW-1:0] chars[$];
    int                         kind;
    int                         v;
    int                         n;
    kind = $urandom_range(0, 99);
    if (kind < 70 || kind >= 95) begin
      v = $urandom_range(int'(spdc_pkg::DutyMin), int'(spdc_pkg::DutyMax));
      if (v >= 100) chars.push_back(spdc_pkg::CharZero + 8'd1);
      chars.push_back(spdc_pkg::CharZero + spdc_pkg::CharW'((v / 10) % 10));
      chars.push_back(spdc_pkg::CharZero + spdc_pkg::CharW'(v % 10));
      // Corrupt one character of a good line.
      if (kind >= 95) chars[$urandom_range(0, chars.size() - 1)] = noise_char();
    end else if (kind < 80) begin
      if ($urandom_range(0, 1) == 0) begin
        chars.push_back(spdc_pkg::CharZero + 8'd6);
        chars.push_back(spdc_pkg::CharZero + spdc_pkg::CharW'($urandom_range(0, 9)));
      end else begin
        chars.push_back(spdc_pkg::CharZero + spdc_pkg::CharW'($urandom_range(0, 1)));
        chars.push_back(spdc_pkg::CharZero + spdc_pkg::CharW'($urandom_range(0, 2)));
        chars.push_back(spdc_pkg::CharZero + spdc_pkg::CharW'($urandom_range(0, 9)));
      end
    end else if (kind < 95 && kind >= 85) begin
      n = $urandom_range(1, 7);
      repeat (n) chars.push_back(noise_char());
    end
    // Kinds 80..84 leave the line empty.
    foreach (chars[i]) send_byte(chars[i]);
    send_byte(spdc_pkg::CharCr);
  endtask

  // Compare every transfer on the output with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result: echo_byte %0d", out_ch.echo_byte);
        error_count++;
      end else begin
        want_res = result_q.pop_front();
        if (out_ch.echo_byte !== want_res.echo_byte) begin
          $error("echo_byte: expected %0d, actual %0d", want_res.echo_byte, out_ch.echo_byte);
          error_count++;
        end
        if (out_ch.event_res !== want_res.event_res) begin
          $error("event_res: expected %0d, actual %0d", want_res.event_res, out_ch.event_res);
          error_count++;
        end
        if (out_ch.axis_next !== want_res.axis_next) begin
          $error("axis_next: expected %0d, actual %0d", want_res.axis_next, out_ch.axis_next);
          error_count++;
        end
        if (out_ch.duty_x !== want_res.duty_x) begin
          $error("duty_x: expected %0d, actual %0d", want_res.duty_x, out_ch.duty_x);
          error_count++;
        end
        if (out_ch.duty_y !== want_res.duty_y) begin
          $error("duty_y: expected %0d, actual %0d", want_res.duty_y, out_ch.duty_y);
          error_count++;
        end
      end
    end
  end

  // Receiver: wait a random number of cycles per result, or hold off for a
  // long stretch when a test asks for it, then take one transfer.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request > 0) begin
        out_ch.ready <= 1'b0;
        for (int held = 0; held < hold_request; held++) @(posedge clk);
        hold_request = 0;
      end else begin
        stall = recv_idle ? $urandom_range(0, 4) : 0;
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Extremes of the value range, both axes, empty line after reset.
  task automatic test_directed_values();
    send_byte(spdc_pkg::CharCr);
    send_line("63");
    send_line("125");
    send_line("62");
    send_line("126");
  endtask

  // Short, long, and non-digit lines, including high-bit bytes.
  task automatic test_directed_malformed();
    send_line("7");
    send_line("12345");
    send_byte(8'hFF);
    send_byte(spdc_pkg::CharZero);
    send_byte(spdc_pkg::CharCr);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(spdc_pkg::CharCr);
  endtask

  task automatic test_random_lines(input int bytes);
    int target;
    target = sent_count + bytes;
    while (sent_count < target) send_random_line();
  endtask

  // Drop all idling on both sides.
  task automatic test_back_to_back(input int bytes);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    test_random_lines(bytes);
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // Stall the output for a long stretch while bytes keep coming, so the
  // pipeline fills and back-pressures the input.
  task automatic test_output_holdoff();
    send_idle    = 1'b0;
    hold_request = HoldCycles;
    test_random_lines(60);
    send_idle = 1'b1;
  endtask

  // Pause the sender after every line until all results have arrived.
  task automatic test_drain_pause();
    repeat (12) begin
      send_random_line();
      wait_drained();
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_values();
    test_directed_malformed();
    test_random_lines(900);
    test_back_to_back(300);
    test_output_holdoff();
    test_drain_pause();
    test_random_lines(250);

    wait_drained();
    repeat (8) @(posedge clk);
    if (result_q.size() != 0) begin
      $error("%0d expected results never arrived", result_q.size());
      error_count++;
    end
    $display("Run covered %0d bytes over %0d cycles with random idling and back-pressure.",
             sent_count, cycle_count);
    $display("Lines: %0d x values, %0d pairs applied, %0d rejected, %0d empty.",
             x_taken_count, applied_count, reject_count, empty_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
